// ===== design/sec_pkg.sv =====
// Shared types and constants for the spatial event coalescer.
// Holds the ring entry layout and the fixed field widths; no dependencies.
package sec_pkg;

	// Kind code that marks a freed ring entry.
	localparam logic [15:0] FREE_KIND = 16'hFFFF;
	// Saturation value of the hit counter.
	localparam logic [14:0] HITS_MAX = 15'h7FFF;
	// Axis distance bits below which a match is still possible.
	localparam int AXIS_BITS = 25;

	// Configuration register indexes.
	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_EXPIRY = 2'd1;
	localparam logic [1:0] REG_BLEND  = 2'd2;
	localparam logic [1:0] REG_RADIUS = 2'd3;

	// One ring entry as stored in the slot memory.
	typedef struct packed {
		logic [15:0]        kind;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [30:0]        stamp;
		logic [14:0]        hits;
	} entry_t;

endpackage

// ===== design/spatial_event_coalescer.sv =====
// Spatial event coalescer: ring of recent events held in one slot memory.
// Depends on sec_pkg for the entry layout and constants.
//
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   event beat, 190 bits in 192
// m_axis    out  m_axis_tvalid/m_axis_tready   notify beat, 173 bits in 176
// cfg       in   cfg_wen                       cfg_idx, cfg_wdata (49 bits)
//
// An event is taken in the idle state and checked, then scanned, each slot
// passing the read and distance pipeline (stages s1 to s3), then committed,
// with a divide step before the commit when it blends into a recent entry
// (one quotient bit a cycle on three axes at once).
// The memory read port scans one slot per cycle. Reset clears pointers and
// control flags; payload and slot contents stay undefined until written.
// A stalled result holds a notifying commit until the output register is free.
module spatial_event_coalescer #(
	parameter int RING_SLOTS      = 32,
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// source_id[31:0], pos_x[63:32], pos_y[95:64], pos_z[127:96],
	// event_kind[142:128], loudness[158:143], now_tick[189:159], zero fill
	input  logic [191:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// notify_source[31:0], notify_kind[46:32], notify_x[78:47],
	// notify_y[110:79], notify_z[142:111], notify_loudness[157:143],
	// notify_hits[172:158], zero fill
	output logic [175:0] m_axis_tdata,
	input  logic         cfg_wen,
	input  logic [1:0]   cfg_idx,
	input  logic [48:0]  cfg_wdata
);

	localparam int IW = $clog2(RING_SLOTS);
	localparam logic [48:0] RADIUS_RST = 49'(1) << (2 * COORD_FRAC_BITS);

	typedef enum logic [2:0] {ST_IDLE, ST_CHECK, ST_SCAN, ST_DIV, ST_COMMIT} state_t;

	function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
		return (i == IW'(RING_SLOTS - 1)) ? '0 : i + 1'b1;
	endfunction

	// Configuration registers.
	logic        enable_q;
	logic [15:0] expiry_q;
	logic [15:0] blend_q;
	logic [48:0] radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			expiry_q <= 16'd120;
			blend_q  <= 16'd30;
			radius_q <= RADIUS_RST;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				sec_pkg::REG_ENABLE: enable_q <= cfg_wdata[0];
				sec_pkg::REG_EXPIRY: expiry_q <= cfg_wdata[15:0];
				sec_pkg::REG_BLEND:  blend_q  <= cfg_wdata[15:0];
				sec_pkg::REG_RADIUS: radius_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Latched event fields.
	logic [31:0]        ev_src_q;
	logic signed [31:0] ev_x_q, ev_y_q, ev_z_q;
	logic [14:0]        ev_kind_q;
	logic [15:0]        ev_loud_q;
	logic [30:0]        ev_now_q;
	logic signed [32:0] live_edge_q, blend_edge_q;

	state_t             state_q;
	logic [IW-1:0]      head_q, tail_q, iss_ptr_q, reuse_q, hit_idx_q;
	logic               have_reuse_q, found_q, recent_hit_q;
	sec_pkg::entry_t    hit_ent_q;
	logic [14:0]        hit_hits_q;
	logic [4:0]         div_cnt_q;
	logic [2:0][24:0]   quo_q;
	logic [2:0][14:0]   rem_q;
	logic [2:0]         neg_q;

	// Output register.
	logic               out_valid_q;
	logic [31:0]        out_src_q;
	logic [14:0]        out_kind_q, out_loud_q, out_hits_q;
	logic [31:0]        out_x_q, out_y_q, out_z_q;

	// Slot memory with one write and one registered read port.
	sec_pkg::entry_t    mem [RING_SLOTS];
	sec_pkg::entry_t    rd_s1;
	logic               mem_we;
	logic [IW-1:0]      mem_waddr;
	sec_pkg::entry_t    mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_s1 <= mem[iss_ptr_q];
	end

	// Scan pipeline registers.
	logic               v_s1, v_s2, v_s3;
	logic [IW-1:0]      idx_s1, idx_s2, idx_s3;
	sec_pkg::entry_t    ent_s2, ent_s3;
	logic [2:0][24:0]   ad_s2, ad_s3;
	logic [2:0]         neg_s2, neg_s3;
	logic               near_s2, near_s3, live_s2, live_s3, rec_s2, rec_s3;
	logic [2:0][49:0]   sq_s3;

	// Stage 2 inputs: axis differences and the far check on the read entry.
	logic signed [2:0][32:0] dif;
	logic [2:0][32:0]        adif;
	logic                    far;
	always_comb begin
		dif[0] = {ev_x_q[31], ev_x_q} - {rd_s1.x[31], rd_s1.x};
		dif[1] = {ev_y_q[31], ev_y_q} - {rd_s1.y[31], rd_s1.y};
		dif[2] = {ev_z_q[31], ev_z_q} - {rd_s1.z[31], rd_s1.z};
		far = 1'b0;
		for (int a = 0; a < 3; a++) begin
			adif[a] = dif[a][32] ? -dif[a] : dif[a];
			far = far | (|adif[a][32:sec_pkg::AXIS_BITS]);
		end
	end

	// Stage 3 decision: squared distance against the radius.
	logic [51:0] dist_sq;
	logic        hit_now, exp_now, issue;
	assign dist_sq = {2'b00, sq_s3[0]} + {2'b00, sq_s3[1]} + {2'b00, sq_s3[2]};
	assign hit_now = (state_q == ST_SCAN) && v_s3 && !found_q && live_s3 && near_s3
		&& (dist_sq < {3'b000, radius_q});
	assign exp_now = (state_q == ST_SCAN) && v_s3 && !found_q && !live_s3;
	assign issue   = (state_q == ST_SCAN) && !found_q && !hit_now && (iss_ptr_q != tail_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1 && !hit_now;
			v_s3 <= v_s2 && !hit_now;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= iss_ptr_q;
		idx_s2 <= idx_s1;
		ent_s2 <= rd_s1;
		for (int a = 0; a < 3; a++) begin
			ad_s2[a]  <= adif[a][24:0];
			neg_s2[a] <= dif[a][32];
		end
		near_s2 <= (rd_s1.kind == {1'b0, ev_kind_q}) && !far;
		live_s2 <= $signed({2'b00, rd_s1.stamp}) > live_edge_q;
		rec_s2  <= $signed({2'b00, rd_s1.stamp}) >= blend_edge_q;
		idx_s3  <= idx_s2;
		ent_s3  <= ent_s2;
		ad_s3   <= ad_s2;
		neg_s3  <= neg_s2;
		near_s3 <= near_s2;
		live_s3 <= live_s2;
		rec_s3  <= rec_s2;
		for (int a = 0; a < 3; a++)
			sq_s3[a] <= ad_s2[a] * ad_s2[a];
	end

	// Commit values: blended or new point, target slot and notify flag.
	logic [2:0][31:0] old_p, new_p, blended;
	logic [IW-1:0]    new_idx;
	logic             notify, commit;
	always_comb begin
		old_p[0] = hit_ent_q.x;
		old_p[1] = hit_ent_q.y;
		old_p[2] = hit_ent_q.z;
		new_p[0] = ev_x_q;
		new_p[1] = ev_y_q;
		new_p[2] = ev_z_q;
		for (int a = 0; a < 3; a++)
			blended[a] = old_p[a] + (neg_q[a] ? -{7'b0, quo_q[a]} : {7'b0, quo_q[a]});
		new_idx = have_reuse_q ? reuse_q : tail_q;
		notify  = !(found_q && recent_hit_q);
		commit  = (state_q == ST_COMMIT) && (!notify || !out_valid_q || m_axis_tready);
	end

	// Memory write: a freed slot during the scan, or the final entry.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s3;
		mem_wdata = ent_s3;
		if (exp_now) begin
			mem_we         = 1'b1;
			mem_wdata.kind = sec_pkg::FREE_KIND;
		end else if (commit) begin
			mem_we = 1'b1;
			if (found_q) begin
				mem_waddr      = hit_idx_q;
				mem_wdata      = hit_ent_q;
				mem_wdata.hits = hit_hits_q;
				mem_wdata.x    = recent_hit_q ? blended[0] : ev_x_q;
				mem_wdata.y    = recent_hit_q ? blended[1] : ev_y_q;
				mem_wdata.z    = recent_hit_q ? blended[2] : ev_z_q;
			end else begin
				mem_waddr       = new_idx;
				mem_wdata.kind  = {1'b0, ev_kind_q};
				mem_wdata.x     = ev_x_q;
				mem_wdata.y     = ev_y_q;
				mem_wdata.z     = ev_z_q;
				mem_wdata.stamp = ev_now_q;
				mem_wdata.hits  = 15'd1;
			end
		end
	end

	// Event latch; payload registers need no reset.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ev_src_q  <= s_axis_tdata[31:0];
			ev_x_q    <= s_axis_tdata[63:32];
			ev_y_q    <= s_axis_tdata[95:64];
			ev_z_q    <= s_axis_tdata[127:96];
			ev_kind_q <= s_axis_tdata[142:128];
			ev_loud_q <= s_axis_tdata[158:143];
			ev_now_q  <= s_axis_tdata[189:159];
		end
		if (state_q == ST_CHECK) begin
			live_edge_q  <= $signed({2'b00, ev_now_q}) - $signed({17'b0, expiry_q});
			blend_edge_q <= $signed({2'b00, ev_now_q}) - $signed({17'b0, blend_q});
		end
	end

	// Sequencer with pointers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			iss_ptr_q    <= '0;
			reuse_q      <= '0;
			hit_idx_q    <= '0;
			have_reuse_q <= 1'b0;
			found_q      <= 1'b0;
			recent_hit_q <= 1'b0;
			div_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// A committed notify loads the output register; a taken beat empties it.
			if (commit && notify)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					found_q      <= 1'b0;
					have_reuse_q <= 1'b0;
					iss_ptr_q    <= head_q;
					if (!enable_q || ev_loud_q[15] || ev_loud_q == '0)
						state_q <= ST_IDLE;
					else
						state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (issue)
						iss_ptr_q <= nxt(iss_ptr_q);
					if (exp_now) begin
						if (idx_s3 == head_q)
							head_q <= nxt(idx_s3);
						else begin
							reuse_q      <= idx_s3;
							have_reuse_q <= 1'b1;
						end
					end
					if (hit_now) begin
						found_q      <= 1'b1;
						hit_idx_q    <= idx_s3;
						recent_hit_q <= rec_s3;
						div_cnt_q    <= '0;
						state_q      <= rec_s3 ? ST_DIV : ST_COMMIT;
					end else if (!issue && !v_s1 && !v_s2 && !v_s3) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 5'(sec_pkg::AXIS_BITS - 1))
						state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (commit) begin
						state_q <= ST_IDLE;
						if (!found_q && !have_reuse_q) begin
							tail_q <= nxt(tail_q);
							if (nxt(tail_q) == head_q)
								head_q <= nxt(head_q);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hit capture, restoring divide lanes and output payload.
	always_ff @(posedge clk) begin
		logic [15:0] rn;
		if (hit_now) begin
			hit_ent_q  <= ent_s3;
			hit_hits_q <= (ent_s3.hits == sec_pkg::HITS_MAX) ? sec_pkg::HITS_MAX
				: ent_s3.hits + 1'b1;
			quo_q <= ad_s3;
			neg_q <= neg_s3;
			rem_q <= '0;
		end
		if (state_q == ST_DIV) begin
			for (int a = 0; a < 3; a++) begin
				rn = {rem_q[a], quo_q[a][24]};
				if (rn >= {1'b0, hit_hits_q}) begin
					rem_q[a] <= 15'(rn - {1'b0, hit_hits_q});
					quo_q[a] <= {quo_q[a][23:0], 1'b1};
				end else begin
					rem_q[a] <= rn[14:0];
					quo_q[a] <= {quo_q[a][23:0], 1'b0};
				end
			end
		end
		if (commit && notify) begin
			out_src_q  <= ev_src_q;
			out_loud_q <= ev_loud_q[14:0];
			if (found_q) begin
				out_kind_q <= hit_ent_q.kind[14:0];
				out_hits_q <= hit_hits_q;
			end else begin
				out_kind_q <= ev_kind_q;
				out_hits_q <= 15'd1;
			end
			out_x_q <= ev_x_q;
			out_y_q <= ev_y_q;
			out_z_q <= ev_z_q;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_hits_q, out_loud_q, out_z_q, out_y_q, out_x_q,
		out_kind_q, out_src_q};

endmodule

// ===== design/sec_checker.sv =====
// Port-level checker for the spatial event coalescer, bound to the top level.
// Depends only on the top-level ports.
module sec_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [175:0] m_axis_tdata
);

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result payload changed while stalled");

	// One event at a time: the input closes right after a beat is taken.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input open in the cycle after an accepted beat");

	// A new result never appears in the cycle right after an input beat.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
		else $error("result too soon after an input beat");

endmodule

bind spatial_event_coalescer sec_checker u_sec_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
